### hw/rtl/urlpd_pkg.sv
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types, constants and hex helpers for the url percent decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

	// escape introducer
	localparam logic [7:0] PCT_CHAR = 8'h25;

	// hex radix as a shift: value = first * 16 + second
	localparam int HEX_SHIFT = 4;

	// most bytes one item can produce
	localparam int MAX_BYTES = 3;
	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_BYTES);

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// escape phase, one-hot
	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_PCT   = 3'b010,
		PH_DIGIT = 3'b100
	} phase_t;

	// decoded bytes of one input item
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          cnt;
		logic                      last;
	} bundle_t;

	// queue status seen by the back part
	typedef struct packed {
		logic    valid;
		bundle_t head;
	} q_head_t;

	// true for 0-9, a-f, A-F
	function automatic logic is_hex(input logic [7:0] b);
		logic dig;
		logic alpha;
		dig   = (b >= 8'h30) && (b <= 8'h39);
		alpha = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
		return dig || alpha;
	endfunction

	// nibble value of a hex digit, zero for anything else
	function automatic logic [3:0] hex_val(input logic [7:0] b);
		logic [3:0] v;
		if ((b >= 8'h30) && (b <= 8'h39)) begin
			v = b[3:0];
		end else if (is_hex(b)) begin
			v = b[3:0] + 4'd9;
		end else begin
			v = 4'd0;
		end
		return v;
	endfunction

endpackage

### hw/rtl/urlpd_front.sv
// ----------------------------------------------------------------------------
// urlpd_front
// Accepts encoded bytes, tracks the escape phase and turns each item into a
// bundle of zero to three decoded bytes for the queue.
// ----------------------------------------------------------------------------
module urlpd_front import urlpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       push,
	output bundle_t    push_data
);

	phase_t     phase_q;
	logic [7:0] held_q;
	phase_t     phase_d;
	logic [7:0] held_d;

	// decode one item against the current phase
	always_comb begin
		logic             fresh;
		logic             cur_hex;
		logic [CNT_W-1:0] n;
		fresh   = 1'b1;
		cur_hex = is_hex(in_byte);
		n       = '0;
		phase_d = phase_q;
		held_d  = held_q;
		push_data = '0;

		unique case (phase_q)
			PH_DIGIT: begin
				if (cur_hex) begin
					push_data.bytes[n[IDX_W-1:0]] = {hex_val(held_q), hex_val(in_byte)};
					n = n + 1'b1;
					fresh = 1'b0;
				end else begin
					push_data.bytes[n[IDX_W-1:0]] = PCT_CHAR;
					n = n + 1'b1;
					push_data.bytes[n[IDX_W-1:0]] = held_q;
					n = n + 1'b1;
				end
				phase_d = PH_IDLE;
			end
			PH_PCT: begin
				if (cur_hex) begin
					held_d  = in_byte;
					phase_d = PH_DIGIT;
					fresh   = 1'b0;
				end else begin
					push_data.bytes[n[IDX_W-1:0]] = PCT_CHAR;
					n = n + 1'b1;
					phase_d = PH_IDLE;
				end
			end
			PH_IDLE: begin
				phase_d = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// byte handled on its own
		if (fresh) begin
			if (in_byte == PCT_CHAR) begin
				phase_d = PH_PCT;
			end else begin
				push_data.bytes[n[IDX_W-1:0]] = in_byte;
				n = n + 1'b1;
			end
		end

		// end of string flushes a pending escape
		if (in_last) begin
			if (phase_d == PH_PCT) begin
				push_data.bytes[n[IDX_W-1:0]] = PCT_CHAR;
				n = n + 1'b1;
			end else if (phase_d == PH_DIGIT) begin
				push_data.bytes[n[IDX_W-1:0]] = PCT_CHAR;
				n = n + 1'b1;
				push_data.bytes[n[IDX_W-1:0]] = held_d;
				n = n + 1'b1;
			end
			phase_d = PH_IDLE;
		end

		push_data.cnt  = n;
		push_data.last = in_last;
	end

	// empty bundles are dropped
	assign push = accept && (push_data.cnt != '0);

	// escape state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

endmodule

### hw/rtl/urlpd_queue.sv
// ----------------------------------------------------------------------------
// urlpd_queue
// Small register queue of decoded bundles between front and back.
// ----------------------------------------------------------------------------
module urlpd_queue import urlpd_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output logic    full,
	output q_head_t status
);

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W_Q = $clog2(Depth + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(Depth - 1);
	localparam logic [CNT_W_Q-1:0] FULL_CNT = CNT_W_Q'(Depth);

	bundle_t            mem_q [Depth];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;

	assign full         = (count_q == FULL_CNT);
	assign status.valid = (count_q != '0);
	assign status.head  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/urlpd_back.sv
// ----------------------------------------------------------------------------
// urlpd_back
// Walks the head bundle one byte per cycle, when not stalled, into the output
// register and marks the string end on the final byte of a closing bundle.
// ----------------------------------------------------------------------------
module urlpd_back import urlpd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  q_head_t    status,
	output logic       pop,
	input  logic       out_stall,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             out_last_q;
	logic             load;
	logic             final_byte;

	// load when the output register is free or being taken
	assign load       = status.valid && (!out_valid_q || !out_stall);
	assign final_byte = (CNT_W'(idx_q) == status.head.cnt - 1'b1);
	assign pop        = load && final_byte;

	// byte index within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= final_byte ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= status.head.bytes[idx_q];
			out_last_q <= status.head.last && final_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

### hw/rtl/url_percent_decoder_core.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_core
// Streaming url percent decoder: one encoded byte in, zero to three bytes out.
// ----------------------------------------------------------------------------
// The block takes one encoded byte per cycle while its queue is not full. The
// front decodes each item in the cycle it is accepted and pushes its zero to
// three result bytes as one bundle into a short queue (QueueDepth bundles);
// the back, unless stalled, sends one byte per cycle from the queue head
// through a registered output. Sustained rate is one item per cycle while each
// item gives at most one byte and the output does not stall; the bytes of one
// item leave one after another, and the input stalls only when the queue is
// full. A final item always gives at least one byte, and its last byte carries
// out_last. Items that give no bytes (a pending escape) are absorbed.
// ----------------------------------------------------------------------------
module url_percent_decoder_core import urlpd_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       out_last
);

	logic    accept;
	logic    push;
	bundle_t push_data;
	logic    pop;
	logic    q_full;
	q_head_t q_status;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// front: escape tracking and decode
	urlpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.push      (push),
		.push_data (push_data)
	);

	// bundle queue
	urlpd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.status    (q_status)
	);

	// back: byte serializer and output register
	urlpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (q_status),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

endmodule

### hw/rtl/urlpd_checker.sv
// ----------------------------------------------------------------------------
// urlpd_checker
// Port-level checks for the url percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module urlpd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       in_last,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a stalled output item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_last))
		else $error("stalled output item changed");

	// a stalled input item holds
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
		else $error("stalled input item changed");

	// nothing shown during reset
	assert property (@(posedge clk) !arst_n |-> !out_valid && !in_stall)
		else $error("output or stall active in reset");

	// input only stalls while the output holds an item
	assert property (@(posedge clk) disable iff (!arst_n) in_stall |-> out_valid)
		else $error("input stalled with idle output");

	// output drops only after being taken
	assert property (@(posedge clk) disable iff (!arst_n) $fell(out_valid) |-> $past(!out_stall))
		else $error("output item withdrawn");

endmodule

bind url_percent_decoder_core urlpd_checker u_urlpd_checker (.*);

### tb/sv/url_percent_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_core_tb
// Self-checking bench for the streaming url percent decoder. Encoded strings
// go in one byte per item, and every decoded byte coming out is compared in
// order with a software decode of the same stream. Directed strings cover the
// escape corner cases, then random strings of escapes, plain bytes and broken
// escapes run under random gaps and stalls on both sides, including one long
// receiver hold-off that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module url_percent_decoder_core_tb import urlpd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 350;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 8;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MAX_REPORTS  = 10;

	// one decoded byte as it should leave the block
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} decoded_t;

	// software decode of the stream and the bytes still owed by the block
	class decode_tracker;
		phase_t     phase;
		logic [7:0] held;
		decoded_t   owed[$];
		int         mismatches;

		function new();
			phase      = PH_IDLE;
			held       = 8'h00;
			mismatches = 0;
		endfunction

		// hex digit value, -1 for any other byte
		function int digit_value(logic [7:0] c);
			if (c >= "0" && c <= "9") begin
				return int'(c) - int'("0");
			end
			if (c >= "a" && c <= "f") begin
				return int'(c) - int'("a") + 10;
			end
			if (c >= "A" && c <= "F") begin
				return int'(c) - int'("A") + 10;
			end
			return -1;
		endfunction

		// decode one accepted item and queue the bytes it yields
		function void take_encoded(logic [7:0] b, logic last);
			logic [7:0] res[3];
			int         n;
			int         v;
			int         value;
			bit         fresh;
			decoded_t   d;
			n     = 0;
			fresh = 1'b1;
			v     = digit_value(b);
			// finish or break a pending escape
			case (phase)
				PH_DIGIT: begin
					if (v >= 0) begin
						value  = (digit_value(held) << HEX_SHIFT) + v;
						res[n] = value[7:0];
						n++;
						fresh  = 1'b0;
					end else begin
						res[n] = PCT_CHAR;
						n++;
						res[n] = held;
						n++;
					end
					phase = PH_IDLE;
				end
				PH_PCT: begin
					if (v >= 0) begin
						held  = b;
						phase = PH_DIGIT;
						fresh = 1'b0;
					end else begin
						res[n] = PCT_CHAR;
						n++;
						phase  = PH_IDLE;
					end
				end
				default: begin
					phase = PH_IDLE;
				end
			endcase
			// byte not consumed by an escape
			if (fresh) begin
				if (b == PCT_CHAR) begin
					phase = PH_PCT;
				end else begin
					res[n] = b;
					n++;
				end
			end
			// end of string flushes what is pending
			if (last) begin
				if (phase == PH_PCT) begin
					res[n] = PCT_CHAR;
					n++;
				end else if (phase == PH_DIGIT) begin
					res[n] = PCT_CHAR;
					n++;
					res[n] = held;
					n++;
				end
				phase = PH_IDLE;
			end
			for (int i = 0; i < n; i++) begin
				d.data = res[i];
				d.last = last && (i == n - 1);
				owed.push_back(d);
			end
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= MAX_REPORTS) begin
				$display("mismatch at %0t: %s", $realtime, msg);
			end
		endfunction

		// compare one accepted output item with the oldest owed byte
		function void check_decoded(logic [7:0] b, logic last);
			decoded_t want;
			if (owed.size() == 0) begin
				note_mismatch($sformatf("unexpected byte %02h last %0b", b, last));
				return;
			end
			want = owed.pop_front();
			if (b !== want.data) begin
				note_mismatch($sformatf("out_byte expected %02h actual %02h",
					want.data, b));
			end
			if (last !== want.last) begin
				note_mismatch($sformatf("out_last expected %0b actual %0b (byte %02h)",
					want.last, last, b));
			end
		endfunction

		function int pending();
			return owed.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       in_last;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] out_byte;
	logic       out_last;

	decode_tracker tracker = new();
	int            items_sent = 0;
	int            cycles     = 0;
	bit            hold_req   = 1'b0;
	bit            hold_active = 1'b0;

	url_percent_decoder_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.out_last  (out_last)
	);

	// clock, 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("url_percent_decoder_core_tb: FAIL");
			$finish;
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			tracker.check_decoded(out_byte, out_last);
		end
	end

	// random hex digit, either case
	function automatic logic [7:0] pick_hex();
		string digits;
		digits = "0123456789abcdefABCDEF";
		return digits[$urandom_range(0, 21)];
	endfunction

	// bytes that break an escape: near the hex ranges or anything at all
	function automatic logic [7:0] pick_noise();
		logic [7:0] edges[7];
		edges = '{8'h2F, 8'h3A, 8'h40, 8'h47, 8'h60, 8'h67, PCT_CHAR};
		if ($urandom_range(0, 1) == 0) begin
			return edges[$urandom_range(0, 6)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// offer one item after a random gap, wait until it is taken
	task automatic send_item(input logic [7:0] b, input logic last);
		int r;
		int gap;
		r   = $urandom_range(0, 9);
		gap = 0;
		if (!hold_active) begin
			if (r >= 9) begin
				gap = $urandom_range(8, 30);
			end else if (r >= 6) begin
				gap = $urandom_range(1, 3);
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		do @(posedge clk); while (in_stall);
		tracker.take_encoded(b, last);
		items_sent++;
	endtask

	// one whole string, last mark on its final byte
	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], i == s.len() - 1);
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int r;
		int run;
		out_stall <= 1'b0;
		forever begin
			if (hold_req) begin
				hold_req    = 1'b0;
				hold_active = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_active = 1'b0;
			end else begin
				r = $urandom_range(0, 9);
				if (r < 4) begin
					run = 0;
				end else if (r < 9) begin
					run = $urandom_range(1, 3);
				end else begin
					run = $urandom_range(10, 40);
				end
				if (run > 0) begin
					out_stall <= 1'b1;
					repeat (run) @(posedge clk);
				end
				out_stall <= 1'b0;
				repeat ($urandom_range(1, (r < 2) ? 30 : 6)) @(posedge clk);
			end
		end
	end

	// stimulus and end of run
	initial begin
		logic [7:0] enc[$];
		int         tokens;
		int         kind;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_byte  <= 8'h00;
		in_last  <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: both hex cases, broken escapes, flush at the end
		send_text("%4a%Ff");
		send_text("%4g");
		send_text("%%41");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_text("%");
		send_text("%0");
		send_text("%G");
		send_text("%4%");
		send_text("%9:");

		// random strings, mostly well-formed escapes
		hold_req = 1'b1;
		while (items_sent < RANDOM_ITEMS) begin
			enc.delete();
			tokens = $urandom_range(1, 4);
			for (int t = 0; t < tokens; t++) begin
				kind = $urandom_range(0, 9);
				if (kind < 5) begin
					enc.push_back(PCT_CHAR);
					enc.push_back(pick_hex());
					enc.push_back(pick_hex());
				end else if (kind < 7) begin
					enc.push_back(8'($urandom_range(0, 255)));
				end else if (kind < 8) begin
					enc.push_back(PCT_CHAR);
					enc.push_back(pick_noise());
				end else if (kind < 9) begin
					enc.push_back(PCT_CHAR);
					enc.push_back(pick_hex());
					enc.push_back(pick_noise());
				end else begin
					// string may end inside an escape
					enc.push_back(PCT_CHAR);
					if ($urandom_range(0, 1) == 1) begin
						enc.push_back(pick_hex());
					end
				end
			end
			for (int i = 0; i < enc.size(); i++) begin
				send_item(enc[i], i == enc.size() - 1);
			end
		end
		in_valid <= 1'b0;

		// drain
		while (tracker.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("url_percent_decoder_core_tb: PASS");
		end else begin
			$display("url_percent_decoder_core_tb: FAIL");
		end
		$finish;
	end

endmodule
